@@ sv/hcwc_pkg.sv @@
// Package for the HSV color window centroid block.
// Holds field widths, register reset values, request and result types,
// and the control and status bundles shared by the controller and datapath.
`timescale 1ns / 1ps

package hcwc_pkg;

  // Field and accumulator widths.
  localparam int COORD_BITS = 16;
  localparam int COUNT_BITS = 19;
  localparam int SUM_BITS   = COORD_BITS + COUNT_BITS;
  localparam int COLOR_BITS = 8;
  localparam int HUE_BITS   = 9;
  localparam int PCT_BITS   = 7;

  // Configuration port.
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = HUE_BITS;

  // Widths of the exact color ratios.
  localparam int HUE_NUM_BITS = 17;  // up to 360 * 255
  localparam int PCT_NUM_BITS = 15;  // up to 100 * 255

  // Color scale factors.
  localparam int HUE_SCALE = 60;
  localparam int PCT_SCALE = 100;
  localparam int VAL_FULL  = 255;

  // Register reset values.
  localparam logic [HUE_BITS-1:0] HUE_LOW_RST  = 9'd0;
  localparam logic [HUE_BITS-1:0] HUE_HIGH_RST = 9'd80;
  localparam logic [PCT_BITS-1:0] SAT_LOW_RST  = 7'd90;
  localparam logic [PCT_BITS-1:0] SAT_HIGH_RST = 7'd105;
  localparam logic [PCT_BITS-1:0] VAL_LOW_RST  = 7'd36;
  localparam logic [PCT_BITS-1:0] VAL_HIGH_RST = 7'd67;

  // Register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_HUE_LOW  = 3'd0,
    CFG_HUE_HIGH = 3'd1,
    CFG_SAT_LOW  = 3'd2,
    CFG_SAT_HIGH = 3'd3,
    CFG_VAL_LOW  = 3'd4,
    CFG_VAL_HIGH = 3'd5
  } cfg_idx_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_RUN,
    ST_DRAIN,
    ST_LOAD,
    ST_DIV
  } ctrl_state_e;

  // One input request: a colored point.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic [COLOR_BITS-1:0]        red;
    logic [COLOR_BITS-1:0]        green;
    logic [COLOR_BITS-1:0]        blue;
    logic                         point_valid;
    logic                         last_point;
  } point_t;

  // One output request: the frame summary.
  typedef struct packed {
    logic                         found;
    logic [COUNT_BITS-1:0]        match_count;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic signed [COORD_BITS-1:0] center_z;
  } result_t;

  // Color window bounds.
  typedef struct packed {
    logic [HUE_BITS-1:0] hue_low;
    logic [HUE_BITS-1:0] hue_high;
    logic [PCT_BITS-1:0] sat_low;
    logic [PCT_BITS-1:0] sat_high;
    logic [PCT_BITS-1:0] val_low;
    logic [PCT_BITS-1:0] val_high;
  } cfg_t;

  // A point leaving the color test.
  typedef struct packed {
    logic                         valid;
    logic                         last;
    logic                         hit;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
  } tested_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_point;   // a point request is accepted this cycle
    logic frame_close;  // start the divisions and clear the sums
    logic out_load;     // move the quotients into the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_done;  // the frame's last point is being accumulated
    logic div_busy;   // the dividers are still iterating
  } dp_status_t;

endpackage

@@ sv/hcwc_color_match.sv @@
// Two-stage color test: RGB to exact hue, saturation and value ratios,
// then strict window compares by cross-multiplication.
// Depends on hcwc_pkg.
`timescale 1ns / 1ps

module hcwc_color_match (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,
  input  hcwc_pkg::point_t  point_i,
  input  hcwc_pkg::cfg_t    cfg_i,
  output hcwc_pkg::tested_t tested_o
);
  import hcwc_pkg::*;

  // Stage one combinational signals.
  logic [COLOR_BITS-1:0]   mx, mn, dlt;
  logic signed [11:0]      r12, g12, b12, d12, t_raw, t_fix;
  logic [HUE_NUM_BITS-1:0] hn_d;
  logic [COLOR_BITS-1:0]   hd_d, sd_d;
  logic [PCT_NUM_BITS-1:0] sn_d, vn_d;

  // Stage one registers.
  logic                    s1_valid_q;
  point_t                  s1_pt_q;
  logic [HUE_NUM_BITS-1:0] s1_hn_q;
  logic [COLOR_BITS-1:0]   s1_hd_q, s1_sd_q;
  logic [PCT_NUM_BITS-1:0] s1_sn_q, s1_vn_q;

  // Stage two combinational signals.
  logic [HUE_NUM_BITS-1:0] hue_lo_p, hue_hi_p;
  logic [PCT_NUM_BITS-1:0] sat_lo_p, sat_hi_p, val_lo_p, val_hi_p;
  logic                    hue_ok, sat_ok, val_ok;

  // Stage two registers.
  logic                         s2_valid_q;
  logic                         s2_last_q, s2_hit_q;
  logic signed [COORD_BITS-1:0] s2_x_q, s2_y_q, s2_z_q;

  // Max, min and the hexcone sector term; hue numerator is 60 times it.
  always_comb begin
    mx = point_i.red;
    mn = point_i.red;
    if (point_i.green > mx) mx = point_i.green;
    if (point_i.blue > mx) mx = point_i.blue;
    if (point_i.green < mn) mn = point_i.green;
    if (point_i.blue < mn) mn = point_i.blue;
    dlt = mx - mn;

    r12 = signed'({4'b0, point_i.red});
    g12 = signed'({4'b0, point_i.green});
    b12 = signed'({4'b0, point_i.blue});
    d12 = signed'({4'b0, dlt});

    if (mx == point_i.red) begin
      t_raw = g12 - b12;
    end else if (mx == point_i.green) begin
      t_raw = (d12 <<< 1) + b12 - r12;
    end else begin
      t_raw = (d12 <<< 2) + r12 - g12;
    end
    // Wrap a negative hue by a full turn, which is six sectors.
    t_fix = (t_raw < 0) ? (t_raw + 12'sd6 * d12) : t_raw;

    hn_d = HUE_NUM_BITS'(t_fix[10:0]) * HUE_NUM_BITS'(HUE_SCALE);
    hd_d = (dlt == '0) ? COLOR_BITS'(1) : dlt;
    sn_d = PCT_NUM_BITS'(dlt) * PCT_NUM_BITS'(PCT_SCALE);
    sd_d = (mx == '0) ? COLOR_BITS'(1) : mx;
    vn_d = PCT_NUM_BITS'(mx) * PCT_NUM_BITS'(PCT_SCALE);
  end

  // Stage one valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= take_i;
    end
  end

  // Stage one payload.
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      s1_pt_q <= point_i;
      s1_hn_q <= hn_d;
      s1_hd_q <= hd_d;
      s1_sn_q <= sn_d;
      s1_sd_q <= sd_d;
      s1_vn_q <= vn_d;
    end
  end

  // Bounds scaled by each ratio's denominator.
  always_comb begin
    hue_lo_p = HUE_NUM_BITS'(cfg_i.hue_low) * HUE_NUM_BITS'(s1_hd_q);
    hue_hi_p = HUE_NUM_BITS'(cfg_i.hue_high) * HUE_NUM_BITS'(s1_hd_q);
    sat_lo_p = PCT_NUM_BITS'(cfg_i.sat_low) * PCT_NUM_BITS'(s1_sd_q);
    sat_hi_p = PCT_NUM_BITS'(cfg_i.sat_high) * PCT_NUM_BITS'(s1_sd_q);
    val_lo_p = PCT_NUM_BITS'(cfg_i.val_low) * PCT_NUM_BITS'(VAL_FULL);
    val_hi_p = PCT_NUM_BITS'(cfg_i.val_high) * PCT_NUM_BITS'(VAL_FULL);
    hue_ok = (s1_hn_q > hue_lo_p) && (s1_hn_q < hue_hi_p);
    sat_ok = (s1_sn_q > sat_lo_p) && (s1_sn_q < sat_hi_p);
    val_ok = (s1_vn_q > val_lo_p) && (s1_vn_q < val_hi_p);
  end

  // Stage two valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  // Stage two payload.
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_last_q <= s1_pt_q.last_point;
      s2_hit_q  <= s1_pt_q.point_valid && hue_ok && sat_ok && val_ok;
      s2_x_q    <= s1_pt_q.pos_x;
      s2_y_q    <= s1_pt_q.pos_y;
      s2_z_q    <= s1_pt_q.pos_z;
    end
  end

  // Tested point bundle.
  always_comb begin
    tested_o.valid = s2_valid_q;
    tested_o.last  = s2_last_q;
    tested_o.hit   = s2_hit_q;
    tested_o.pos_x = s2_x_q;
    tested_o.pos_y = s2_y_q;
    tested_o.pos_z = s2_z_q;
  end

endmodule

@@ sv/hcwc_divider.sv @@
// Radix-2 restoring divider: signed sum over unsigned count, quotient
// truncated toward zero, one quotient bit per cycle.
// Depends on hcwc_pkg.
`timescale 1ns / 1ps

module hcwc_divider (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [hcwc_pkg::SUM_BITS-1:0]  dividend_i,
  input  logic [hcwc_pkg::COUNT_BITS-1:0]       divisor_i,
  output logic                                  busy_o,
  output logic signed [hcwc_pkg::COORD_BITS-1:0] quotient_o
);
  import hcwc_pkg::*;

  localparam int StepBits = $clog2(SUM_BITS);
  localparam logic [StepBits-1:0] LastStep = StepBits'(SUM_BITS - 1);

  logic                  busy_q, busy_d;
  logic [StepBits-1:0]   cnt_q, cnt_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [COUNT_BITS-1:0] den_q, den_d;
  logic [SUM_BITS-1:0]   quo_q, quo_d;
  logic                  neg_q, neg_d;
  logic [COUNT_BITS:0]   trial, diff;
  logic                  ge;
  logic [SUM_BITS-1:0]   quo_signed;

  // One shift-and-subtract step; the dividend bits shift out of quo_q
  // as the quotient bits shift in.
  always_comb begin
    trial = {rem_q, quo_q[SUM_BITS-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};

    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    neg_d  = neg_q;

    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = LastStep;
      rem_d  = '0;
      den_d  = divisor_i;
      neg_d  = dividend_i[SUM_BITS-1];
      quo_d  = dividend_i[SUM_BITS-1] ? (~dividend_i + 1'b1) : dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      quo_d = {quo_q[SUM_BITS-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
  end

  // Restore the sign; the magnitude never exceeds the coordinate range.
  assign quo_signed = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign quotient_o = quo_signed[COORD_BITS-1:0];
  assign busy_o     = busy_q;

endmodule

@@ sv/hcwc_datapath.sv @@
// Datapath: window registers, color test, coordinate sums and count,
// three dividers for the centroid and the result register.
// Depends on hcwc_pkg, hcwc_color_match and hcwc_divider.
`timescale 1ns / 1ps

module hcwc_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hcwc_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [hcwc_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  hcwc_pkg::point_t                    point_i,
  input  hcwc_pkg::ctrl_cmd_t                 cmd_i,
  output hcwc_pkg::dp_status_t                sts_o,
  output hcwc_pkg::result_t                   result_o
);
  import hcwc_pkg::*;

  cfg_t                         cfg_q;
  tested_t                      tested;
  logic signed [SUM_BITS-1:0]   sum_x_q, sum_y_q, sum_z_q;
  logic signed [SUM_BITS-1:0]   sum_x_d, sum_y_d, sum_z_d;
  logic [COUNT_BITS-1:0]        count_q, count_d;
  logic [COUNT_BITS-1:0]        frame_cnt_q;
  logic                         add_point;
  logic [2:0]                   div_busy;
  logic signed [COORD_BITS-1:0] quo_x, quo_y, quo_z;
  result_t                      res_q;

  // Window registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hue_low  <= HUE_LOW_RST;
      cfg_q.hue_high <= HUE_HIGH_RST;
      cfg_q.sat_low  <= SAT_LOW_RST;
      cfg_q.sat_high <= SAT_HIGH_RST;
      cfg_q.val_low  <= VAL_LOW_RST;
      cfg_q.val_high <= VAL_HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HUE_LOW:  cfg_q.hue_low  <= cfg_data_i;
        CFG_HUE_HIGH: cfg_q.hue_high <= cfg_data_i;
        CFG_SAT_LOW:  cfg_q.sat_low  <= cfg_data_i[PCT_BITS-1:0];
        CFG_SAT_HIGH: cfg_q.sat_high <= cfg_data_i[PCT_BITS-1:0];
        CFG_VAL_LOW:  cfg_q.val_low  <= cfg_data_i[PCT_BITS-1:0];
        CFG_VAL_HIGH: cfg_q.val_high <= cfg_data_i[PCT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Color test pipeline.
  hcwc_color_match u_color (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (cmd_i.take_point),
    .point_i  (point_i),
    .cfg_i    (cfg_q),
    .tested_o (tested)
  );

  // Accumulate matches until the count is full; clear at frame close.
  always_comb begin
    add_point = tested.valid && tested.hit && (count_q != '1);
    sum_x_d   = sum_x_q;
    sum_y_d   = sum_y_q;
    sum_z_d   = sum_z_q;
    count_d   = count_q;
    if (cmd_i.frame_close) begin
      sum_x_d = '0;
      sum_y_d = '0;
      sum_z_d = '0;
      count_d = '0;
    end else if (add_point) begin
      sum_x_d = sum_x_q + SUM_BITS'(tested.pos_x);
      sum_y_d = sum_y_q + SUM_BITS'(tested.pos_y);
      sum_z_d = sum_z_q + SUM_BITS'(tested.pos_z);
      count_d = count_q + 1'b1;
    end
  end

  // Sums and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q <= '0;
      sum_y_q <= '0;
      sum_z_q <= '0;
      count_q <= '0;
    end else begin
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
      sum_z_q <= sum_z_d;
      count_q <= count_d;
    end
  end

  // Count of the frame under division.
  always_ff @(posedge clk_i) begin
    if (cmd_i.frame_close) begin
      frame_cnt_q <= count_q;
    end
  end

  // Centroid dividers, started together.
  hcwc_divider u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.frame_close),
    .dividend_i (sum_x_q),
    .divisor_i  (count_q),
    .busy_o     (div_busy[0]),
    .quotient_o (quo_x)
  );

  hcwc_divider u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.frame_close),
    .dividend_i (sum_y_q),
    .divisor_i  (count_q),
    .busy_o     (div_busy[1]),
    .quotient_o (quo_y)
  );

  hcwc_divider u_div_z (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.frame_close),
    .dividend_i (sum_z_q),
    .divisor_i  (count_q),
    .busy_o     (div_busy[2]),
    .quotient_o (quo_z)
  );

  // Result register; an empty frame gives all zeros.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_q.found       <= (frame_cnt_q != '0);
      res_q.match_count <= frame_cnt_q;
      res_q.center_x    <= (frame_cnt_q != '0) ? quo_x : '0;
      res_q.center_y    <= (frame_cnt_q != '0) ? quo_y : '0;
      res_q.center_z    <= (frame_cnt_q != '0) ? quo_z : '0;
    end
  end

  assign result_o        = res_q;
  assign sts_o.last_done = tested.valid && tested.last;
  assign sts_o.div_busy  = |div_busy;

endmodule

@@ sv/hcwc_ctrl.sv @@
// Controller: accepts points, closes the frame after its last point has
// been accumulated, sequences the divisions and owns the output valid.
// Depends on hcwc_pkg.
`timescale 1ns / 1ps

module hcwc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_last_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  hcwc_pkg::dp_status_t sts_i,
  output hcwc_pkg::ctrl_cmd_t  cmd_o
);
  import hcwc_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  // The result slot can take a new result when empty or being emptied.
  assign out_free = !out_valid_q || out_ready_i;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_RUN: begin
        in_ready_o       = 1'b1;
        cmd_o.take_point = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts_i.last_done) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.frame_close = 1'b1;
        state_d           = ST_DIV;
      end
      ST_DIV: begin
        if (!sts_i.div_busy && out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  // Output valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // State and flag registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten while pending");

  // The dividers are running the cycle after the frame closes.
  a_div_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.frame_close |=> sts_i.div_busy)
    else $error("dividers did not start");

  // The last point reaches the sums only while the pipeline drains.
  a_last_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.last_done |-> (state_q == ST_DRAIN))
    else $error("last point arrived outside drain");

  // A new result only comes out of the division state.
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DIV))
    else $error("result raised outside division");
`endif

endmodule

@@ sv/hsv_color_window_centroid.sv @@
// Top level of the HSV color window centroid block.
// Depends on hcwc_pkg, hcwc_ctrl and hcwc_datapath.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   in_req_i  (hcwc_pkg::point_t)
//   out      output     out_valid_o / out_ready_i out_req_o (hcwc_pkg::result_t)
//   cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// Within a frame one point request is accepted every cycle.
// After a frame's last point, input stays closed while the color
// pipeline drains, the frame closes, the radix-2 dividers run at one
// quotient bit per cycle, and the quotients are loaded.
// A finished result waits in its own register; the next frame's points
// are accepted meanwhile. If that result is still waiting when the next
// frame's quotients are ready, the load and the input wait until it is
// taken. Reset is asynchronous and active low.
`timescale 1ns / 1ps

module hsv_color_window_centroid (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  hcwc_pkg::point_t                   in_req_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output hcwc_pkg::result_t                  out_req_o,
  input  logic                               cfg_we_i,
  input  logic [hcwc_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [hcwc_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  import hcwc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // Controller.
  hcwc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_req_i.last_point),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath.
  hcwc_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .point_i    (in_req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .result_o   (out_req_o)
  );

endmodule
